[rtl/core/gb2312_glyph_address_lookup_unit_assert.svh]
// ----------------------------------------------------------------------------
// GB2312 glyph address lookup - assertion macros
// Shared concurrent assertion forms used by the lookup unit's checker.
// ----------------------------------------------------------------------------
`ifndef GB2312_GLYPH_ADDRESS_LOOKUP_UNIT_ASSERT_SVH
`define GB2312_GLYPH_ADDRESS_LOOKUP_UNIT_ASSERT_SVH

// Assertion that is held off while reset is asserted (active low).
`define GGA_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Assertion checked at every edge, reset included.
`define GGA_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/gga_pkg.sv]
// ----------------------------------------------------------------------------
// GB2312 glyph address lookup - package
// Table geometry, register indexes, request codes and code-page constants.
// ----------------------------------------------------------------------------
package gga_pkg;

    // custom code table
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CODE_W      = 16;

    // configuration
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_STANDARD_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_BASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_THRESHOLD = 3'd5;

    // request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // code page layout
    localparam logic [7:0]  ROW_FIRST   = 8'hA1;  // first row / first column
    localparam logic [7:0]  ROW_GAP     = 8'hAA;  // first skipped row
    localparam logic [7:0]  ROW_RESUME  = 8'hB0;  // first row after the gap
    localparam logic [7:0]  ROW_END     = 8'hF8;  // one past the last row
    localparam logic [7:0]  ROW_GAP_ADJ = 8'hA7;  // row bias after the gap
    localparam logic [7:0]  BYTE_MAX    = 8'hFF;
    localparam logic [15:0] ROW_CELLS   = 16'd94;

    // address arithmetic
    localparam int ADDR_W = 32;
    localparam int IDX_W  = 16;
    localparam int SIZE_W = 14;                 // ceil(w/8) * h <= 32 * 255
    localparam int PROD_W = SIZE_W + IDX_W;

endpackage

[rtl/core/gga_ram.sv]
// ----------------------------------------------------------------------------
// GB2312 glyph address lookup - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gga_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/gga_addr_unit.sv]
// ----------------------------------------------------------------------------
// GB2312 glyph address lookup - address unit
// Glyph size register, size * index product register, final base add.
// ----------------------------------------------------------------------------
module gga_addr_unit
    import gga_pkg::*;
(
    input  logic              aclk,
    input  logic [7:0]        glyph_width,
    input  logic [7:0]        glyph_height,
    input  logic              mul_en,
    input  logic [IDX_W-1:0]  index,
    input  logic [ADDR_W-1:0] base,
    output logic [ADDR_W-1:0] addr
);

    logic [8:0]        width_round;
    logic [5:0]        row_bytes;
    logic [SIZE_W-1:0] size_next;
    logic [SIZE_W-1:0] size_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;

    // bytes per row = ceil(width / 8)
    assign width_round = {1'b0, glyph_width} + 9'd7;
    assign row_bytes   = width_round[8:3];
    assign size_next   = SIZE_W'(row_bytes) * SIZE_W'(glyph_height);
    assign prod_next   = PROD_W'(size_reg) * PROD_W'(index);

    always_ff @(posedge aclk) begin
        size_reg <= size_next;
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

    assign addr = base + ADDR_W'(prod_reg);

endmodule

[rtl/core/gb2312_glyph_address_lookup_unit.sv]
// Lookup path: a rejected code, an out-of-page row or an empty table goes straight to FIN;
//   a hit passes MUL before FIN, and a custom lookup first searches the table in SCAN.
// Throughput: one lookup in flight; the next is taken the cycle after the result is
//   registered. The custom search reads one table entry per cycle from the single
//   read port of the code-table RAM, over at most min(table_count, TABLE_DEPTH) entries.
// Load items are taken every cycle while idle. Reset (aresetn low, synchronous) restores
//   the register defaults and empties the result stage; the code table is not cleared.
// ----------------------------------------------------------------------------
// GB2312 glyph address lookup unit
// Decides whether a glyph exists for a two-byte code and returns its address.
// ----------------------------------------------------------------------------
module gb2312_glyph_address_lookup_unit
    import gga_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,

    // request items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [7:0]           s_entry_index,
    input  logic [CODE_W-1:0]    s_entry_code,
    input  logic [7:0]           s_high_byte,
    input  logic [7:0]           s_low_byte,

    // result items
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_available,
    output logic [ADDR_W-1:0]    m_glyph_addr
);

    // Sequencer: SCAN walks the code table, MUL forms size * index,
    // FIN adds the base and parks the item in the output register.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [ADDR_W-1:0] std_base_reg;
    logic [ADDR_W-1:0] cust_base_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [7:0]        width_reg;
    logic [7:0]        height_reg;
    logic [7:0]        thr_reg;

    // lookup context
    logic [7:0]        hi_reg, hi_next;
    logic [7:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              found_reg, found_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic              m_avail_reg;
    logic [ADDR_W-1:0] m_addr_reg;

    // datapath
    logic              accept;
    logic              bytes_ok;
    logic              custom_mode;
    logic              row_ok;
    logic [15:0]       row_off;
    logic [15:0]       pos;
    logic [CNT_W:0]    hdr_half;
    logic [CNT_W+1:0]  hdr_bytes;
    logic [CNT_W-1:0]  limit;
    logic              table_wr;
    logic              rd_en;
    logic [CODE_W-1:0] rd_data;
    logic              entry_match;
    logic              mul_en;
    logic              fin_load;
    logic [ADDR_W-1:0] unit_addr;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            std_base_reg  <= '0;
            cust_base_reg <= '0;
            count_reg     <= '0;
            width_reg     <= 8'd16;
            height_reg    <= 8'd16;
            thr_reg       <= 8'd160;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STANDARD_BASE:  std_base_reg  <= cfg_data;
                REG_CUSTOM_BASE:    cust_base_reg <= cfg_data;
                REG_TABLE_COUNT:    count_reg     <= cfg_data[CNT_W-1:0];
                REG_GLYPH_WIDTH:    width_reg     <= cfg_data[7:0];
                REG_GLYPH_HEIGHT:   height_reg    <= cfg_data[7:0];
                REG_LEAD_THRESHOLD: thr_reg       <= cfg_data[7:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // code checks and standard-mode position
    // ------------------------------------------------------------------
    assign bytes_ok    = (s_high_byte > thr_reg) && (s_low_byte > thr_reg)
                      && (s_low_byte != BYTE_MAX);
    assign custom_mode = (cust_base_reg != '0);
    assign row_ok      = (s_high_byte < ROW_GAP)
                      || ((s_high_byte >= ROW_RESUME) && (s_high_byte < ROW_END));

    // 16-bit wrapping arithmetic: a lowered threshold lets bytes below 0xA1 in
    assign row_off = {8'h00, s_high_byte}
                   - {8'h00, ((s_high_byte < ROW_GAP) ? ROW_FIRST : ROW_GAP_ADJ)};
    assign pos     = 16'(row_off * ROW_CELLS) + ({8'h00, s_low_byte} - {8'h00, ROW_FIRST});

    // custom font: two header bytes per table entry plus two for the count word
    assign hdr_half  = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign hdr_bytes = {hdr_half, 1'b0};

    // search span is min(table_count, TABLE_DEPTH)
    assign limit = (int'(count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_reg;

    assign entry_match = (rd_data == {hi_reg, lo_reg});

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        scan_next  = scan_reg;
        idx_next   = idx_reg;
        base_next  = base_reg;
        found_next = found_reg;
        rd_en      = 1'b0;
        mul_en     = 1'b0;
        fin_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_req_type == REQ_LOOKUP)) begin
                    hi_next    = s_high_byte;
                    lo_next    = s_low_byte;
                    found_next = 1'b0;
                    priority if (!bytes_ok) begin
                        state_next = ST_FIN;
                    end else if (custom_mode) begin
                        base_next = cust_base_reg + ADDR_W'(hdr_bytes);
                        if (limit == '0) begin
                            state_next = ST_FIN;   // empty table never hits
                        end else begin
                            scan_next  = '0;
                            rd_en      = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end else if (row_ok) begin
                        base_next  = std_base_reg;
                        idx_next   = pos;
                        found_next = 1'b1;
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_FIN;       // row in the gap or past the end
                    end
                end
            end
            ST_SCAN: begin
                // rd_data holds entry scan_reg, read the cycle before
                priority if (entry_match) begin
                    found_next = 1'b1;
                    idx_next   = IDX_W'(scan_reg);
                    state_next = ST_MUL;
                end else if (scan_reg + CNT_W'(1) == limit) begin
                    state_next = ST_FIN;
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                    rd_en     = 1'b1;
                end
            end
            ST_MUL: begin
                mul_en     = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    fin_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        scan_reg  <= scan_next;
        idx_reg   <= idx_next;
        base_reg  <= base_next;
        found_reg <= found_next;
    end

    // ------------------------------------------------------------------
    // code table; loads and searches never overlap, so no forwarding
    // ------------------------------------------------------------------
    assign table_wr = accept && (s_req_type == REQ_LOAD)
                   && (int'(s_entry_index) < TABLE_DEPTH);

    gga_ram #(
        .WIDTH (CODE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_code_table (
        .aclk    (aclk),
        .wr_en   (table_wr),
        .wr_addr (TABLE_AW'(s_entry_index)),
        .wr_data (s_entry_code),
        .rd_en   (rd_en),
        .rd_addr (TABLE_AW'(scan_next)),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // address arithmetic
    // ------------------------------------------------------------------
    gga_addr_unit u_addr (
        .aclk         (aclk),
        .glyph_width  (width_reg),
        .glyph_height (height_reg),
        .mul_en       (mul_en),
        .index        (idx_reg),
        .base         (base_reg),
        .addr         (unit_addr)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    assign m_valid_next = (m_valid_reg && !m_ready) || fin_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            m_avail_reg <= found_reg;
            m_addr_reg  <= found_reg ? unit_addr : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_available  = m_avail_reg;
    assign m_glyph_addr = m_addr_reg;

endmodule

[rtl/core/gga_checker.sv]
// ----------------------------------------------------------------------------
// GB2312 glyph address lookup - port checker
// Watches the lookup unit's ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "gb2312_glyph_address_lookup_unit_assert.svh"

module gga_checker
    import gga_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_req_type,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_available,
    input logic [ADDR_W-1:0] m_glyph_addr
);

    // result stage is empty right after reset
    `GGA_ASSERT(a_reset_empties_output, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    // a missing glyph reports address zero
    `GGA_ASSERT_RST(a_miss_addr_zero, aclk, aresetn, m_valid && !m_available |-> m_glyph_addr == '0, "nonzero address on miss")

    // an accepted lookup takes the unit out of idle, so s_ready drops
    `GGA_ASSERT_RST(a_lookup_busy, aclk, aresetn, s_valid && s_ready && s_req_type == REQ_LOOKUP |=> !s_ready, "ready right after lookup")

    // a stalled result stays offered and unchanged
    `GGA_ASSERT_RST(a_out_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `GGA_ASSERT_RST(a_out_hold_addr, aclk, aresetn, m_valid && !m_ready |=> $stable(m_glyph_addr), "address changed while stalled")

endmodule

bind gb2312_glyph_address_lookup_unit gga_checker u_checker (.*);
